// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Item kinds, result codes, sequencer states and the result record that
// travels between the sequencer and the output stage.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Fixed field widths of the channels.
    localparam int ID_W        = 4;
    localparam int PORT_TIME_W = 32;
    localparam int ID_SPACE    = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 40;

    // Defaults of the top level parameters.
    localparam int TIMERS_DEF    = 16;
    localparam int TIME_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_ADJUST = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_DONE   = 2'd0,
        RES_FIRED  = 2'd1,
        RES_NONE   = 2'd2,
        RES_BAD_ID = 2'd3
    } evres_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_CHECK,
        ST_RESP
    } state_t;

    typedef struct packed {
        evres_t                   event_res;
        logic [ID_W-1:0]          fired_id;
        logic [PORT_TIME_W-1:0]   fired_expire;
        logic                     last;
    } res_t;

endpackage

// File: rtl/stq_out_stage.sv
// ----------------------------------------------------------------------------
// stq_out_stage: result register of the sorted timer queue
// Holds one result item until the receiver takes it and packs it onto the
// master-side stream ports.
// ----------------------------------------------------------------------------
module stq_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  stq_pkg::res_t                    load_data,
    output logic                             free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0 up: fired_id[3:0], fired_expire[35:4], zero fill
    output logic [stq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0 up: event_res[1:0]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    logic          valid_reg;
    stq_pkg::res_t data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, data_reg.fired_expire, data_reg.fired_id};
    assign m_tuser  = data_reg.event_res;
    assign m_tlast  = data_reg.last;

endmodule

// File: rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue: table of timers kept in ascending expiry order
// A small sequencer walks the order table one position per cycle to
// insert, remove and expire timers.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ stream: s_tuser carries the kind (add,
// adjust, delete, tick), s_tdata the timer id, the expiry and the current
// time. Results leave on the m_ stream: m_tuser carries the result code,
// m_tdata the timer id and its expiry, and m_tlast marks the final result
// of an item. Every item gives one result, except a tick that expires
// several timers, which gives one result per expired timer in table order.
// The block takes one item at a time: s_tready is high only while the
// sequencer is idle, also while a finished result still waits in the
// output register. An add walks the table backward from the tail, one
// insertion step per position passed; a delete walks the whole table
// forward, and an adjust does the same walk and then the backward
// insertion. A tick checks the front of the table, and every timer that
// it expires costs one walk over the table to close the gap at the front.
// A failing item goes straight from the idle state to the response. When
// the receiver stalls, the result waits in the output register and the
// sequencer holds before it would load the next one. A synchronous reset
// empties the table at once (presence bits and timer count cleared).
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
    parameter int TIMERS    = stq_pkg::TIMERS_DEF,
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0 up: timer_id[3:0], expire_time[35:4],
    // now_time[67:36], zero fill
    input  logic [stq_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0 up: kind[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0 up: fired_id[3:0], fired_expire[35:4], zero fill
    output logic [stq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0 up: event_res[1:0]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    // Only ids below both TIMERS and the id space can ever be held.
    localparam int SLOTS  = (TIMERS < stq_pkg::ID_SPACE) ? TIMERS : stq_pkg::ID_SPACE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Storage: order table, expiry per id and presence bits.
    logic [SLOT_W-1:0]    order_mem [SLOTS];
    logic [TIME_BITS-1:0] expiry_mem [SLOTS];
    logic [SLOTS-1:0]     present_reg;

    stq_pkg::state_t      state_reg, state_next;
    stq_pkg::kind_t       kind_reg, kind_next;
    logic [stq_pkg::ID_W-1:0] id_reg, id_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 found_reg, found_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_id_reg, pend_id_next;
    logic [TIME_BITS-1:0] pend_exp_reg, pend_exp_next;
    stq_pkg::res_t        resp_reg, resp_next;

    // Write and read controls of the storage.
    logic                 ord_we;
    logic [SLOT_W-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic                 exp_we;
    logic [SLOT_W-1:0]    exp_waddr;
    logic [TIME_BITS-1:0] exp_rdata;
    logic                 pres_we, pres_wdata;
    logic [SLOT_W-1:0]    pres_waddr;

    logic                 out_load, out_free;
    stq_pkg::res_t        out_data;

    // Input fields.
    stq_pkg::kind_t           in_kind;
    logic [stq_pkg::ID_W-1:0] in_id;
    logic [SLOT_W-1:0]        in_slot;
    logic [TIME_BITS-1:0]     in_exp, in_now;
    logic                     in_id_ok, in_present;

    logic [SLOT_W-1:0]    idx_slot, id_slot;
    logic                 hit, fire;

    assign in_kind    = stq_pkg::kind_t'(s_tuser);
    assign in_id      = s_tdata[3:0];
    assign in_slot    = in_id[SLOT_W-1:0];
    assign in_exp     = TIME_BITS'(s_tdata[35:4]);
    assign in_now     = TIME_BITS'(s_tdata[67:36]);
    assign in_id_ok   = int'(in_id) < SLOTS;
    assign in_present = present_reg[in_slot];

    assign idx_slot  = idx_reg[SLOT_W-1:0];
    assign id_slot   = id_reg[SLOT_W-1:0];
    assign ord_rdata = order_mem[ord_raddr];
    assign exp_rdata = expiry_mem[ord_rdata];

    assign s_tready = (state_reg == stq_pkg::ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        exp_next        = exp_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_exp_next   = pend_exp_reg;
        resp_next       = resp_reg;
        ord_we          = 1'b0;
        ord_waddr       = '0;
        ord_wdata       = '0;
        ord_raddr       = '0;
        exp_we          = 1'b0;
        exp_waddr       = '0;
        pres_we         = 1'b0;
        pres_waddr      = '0;
        pres_wdata      = 1'b0;
        out_load        = 1'b0;
        out_data        = '0;
        hit             = 1'b0;
        fire            = 1'b0;

        case (state_reg)
            stq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next = in_kind;
                    id_next   = in_id;
                    exp_next  = in_exp;
                    now_next  = in_now;
                    resp_next = '{stq_pkg::RES_BAD_ID, in_id, '0, 1'b1};
                    case (in_kind)
                        stq_pkg::KIND_TICK: begin
                            pend_valid_next = 1'b0;
                            state_next      = stq_pkg::ST_CHECK;
                        end
                        stq_pkg::KIND_ADD: begin
                            if (!in_id_ok || in_present) begin
                                state_next = stq_pkg::ST_RESP;
                            end else begin
                                pres_we    = 1'b1;
                                pres_waddr = in_slot;
                                pres_wdata = 1'b1;
                                exp_we     = 1'b1;
                                exp_waddr  = in_slot;
                                idx_next   = count_reg;
                                resp_next  = '{stq_pkg::RES_DONE, in_id,
                                               stq_pkg::PORT_TIME_W'(in_exp), 1'b1};
                                state_next = stq_pkg::ST_INSERT;
                            end
                        end
                        default: begin
                            if (!in_id_ok || !in_present) begin
                                state_next = stq_pkg::ST_RESP;
                            end else begin
                                idx_next   = '0;
                                found_next = 1'b0;
                                if (in_kind == stq_pkg::KIND_ADJUST) begin
                                    exp_we    = 1'b1;
                                    exp_waddr = in_slot;
                                    resp_next = '{stq_pkg::RES_DONE, in_id,
                                                  stq_pkg::PORT_TIME_W'(in_exp), 1'b1};
                                end else begin
                                    pres_we    = 1'b1;
                                    pres_waddr = in_slot;
                                    pres_wdata = 1'b0;
                                    resp_next  = '{stq_pkg::RES_DONE, in_id, '0, 1'b1};
                                end
                                state_next = stq_pkg::ST_REMOVE;
                            end
                        end
                    endcase
                end
            end

            // Walk forward: once the id is found, every later entry moves
            // one position toward the front.
            stq_pkg::ST_REMOVE: begin
                ord_raddr  = idx_slot;
                hit        = found_reg || (ord_rdata == id_slot);
                found_next = hit;
                if (found_reg) begin
                    ord_we    = 1'b1;
                    ord_waddr = idx_slot - SLOT_W'(1);
                    ord_wdata = ord_rdata;
                end
                if (idx_reg == count_reg - CNT_W'(1)) begin
                    count_next = count_reg - CNT_W'(1);
                    case (kind_reg)
                        stq_pkg::KIND_ADJUST: begin
                            idx_next   = count_reg - CNT_W'(1);
                            state_next = stq_pkg::ST_INSERT;
                        end
                        stq_pkg::KIND_TICK: state_next = stq_pkg::ST_CHECK;
                        default:            state_next = stq_pkg::ST_RESP;
                    endcase
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // Walk backward from the tail: entries with a later expiry move
            // up by one; the new id lands after the last entry that is not
            // later, so equal expiries keep their insertion order.
            stq_pkg::ST_INSERT: begin
                ord_raddr = idx_slot - SLOT_W'(1);
                ord_we    = 1'b1;
                ord_waddr = idx_slot;
                if (idx_reg != '0 && exp_rdata > exp_reg) begin
                    ord_wdata = ord_rdata;
                    idx_next  = idx_reg - CNT_W'(1);
                end else begin
                    ord_wdata  = id_slot;
                    count_next = count_reg + CNT_W'(1);
                    state_next = stq_pkg::ST_RESP;
                end
            end

            // Look at the front of the table. A timer taken earlier is held
            // back until it is known whether it is the final one of the tick.
            stq_pkg::ST_CHECK: begin
                ord_raddr = '0;
                fire      = (count_reg != '0) && (now_reg >= exp_rdata);
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_data = '{stq_pkg::RES_FIRED, stq_pkg::ID_W'(pend_id_reg),
                                     stq_pkg::PORT_TIME_W'(pend_exp_reg), !fire};
                        if (!fire) begin
                            pend_valid_next = 1'b0;
                            state_next      = stq_pkg::ST_IDLE;
                        end
                    end
                end else if (!fire) begin
                    resp_next  = '{stq_pkg::RES_NONE, '0, '0, 1'b1};
                    state_next = stq_pkg::ST_RESP;
                end
                if (fire && (!pend_valid_reg || out_free)) begin
                    pend_valid_next = 1'b1;
                    pend_id_next    = ord_rdata;
                    pend_exp_next   = exp_rdata;
                    pres_we         = 1'b1;
                    pres_waddr      = ord_rdata;
                    pres_wdata      = 1'b0;
                    id_next         = stq_pkg::ID_W'(ord_rdata);
                    idx_next        = '0;
                    found_next      = 1'b0;
                    state_next      = stq_pkg::ST_REMOVE;
                end
            end

            stq_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = resp_reg;
                    state_next = stq_pkg::ST_IDLE;
                end
            end

            default: state_next = stq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= stq_pkg::ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            present_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            if (pres_we) begin
                present_reg[pres_waddr] <= pres_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        exp_reg      <= exp_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        pend_id_reg  <= pend_id_next;
        pend_exp_reg <= pend_exp_next;
        resp_reg     <= resp_next;
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        if (exp_we) begin
            expiry_mem[exp_waddr] <= in_exp;
        end
    end

    stq_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The timer count never exceeds the number of usable ids.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("timer count beyond table size");

    // Between items the count matches the presence bits.
    a_count_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stq_pkg::ST_IDLE) |-> ($countones(present_reg) == int'(count_reg)))
        else $error("timer count and presence bits disagree");

    // The insertion walk never starts beyond the tail.
    a_insert_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stq_pkg::ST_INSERT) |-> (idx_reg <= count_reg))
        else $error("insertion index beyond tail");

    // A held expired timer exists only while a tick is in progress.
    a_pend_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && state_reg != stq_pkg::ST_IDLE) |-> (kind_reg == stq_pkg::KIND_TICK))
        else $error("pending fired timer outside a tick");

endmodule
